/* hdl/cmfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cmfd_pkg;

    // default sizes handed to the top level
    localparam int CMFD_WINDOW_LEN     = 10;
    localparam int CMFD_CHASSIS_MOTORS = 4;

    // sample and running sum widths (sum covers the longest window of 16)
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 20;

    // frame identifiers
    localparam logic [10:0] ID_CHASSIS_BASE = 11'h201;
    localparam logic [10:0] ID_GIMBAL_0     = 11'h205;
    localparam logic [10:0] ID_GIMBAL_1     = 11'h206;
    localparam logic [10:0] ID_FEEDER       = 11'h207;

    // gimbal angle fold points
    localparam logic [15:0] FOLD_MID  = 16'd4096;
    localparam logic [15:0] FOLD_SPAN = 16'd8192;

    // source kinds
    localparam logic [1:0] KIND_CHASSIS = 2'd0;
    localparam logic [1:0] KIND_GIMBAL  = 2'd1;
    localparam logic [1:0] KIND_FEEDER  = 2'd2;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [63:0] payload;
    } cmfd_frame_t;

    typedef struct packed {
        logic        [1:0]  source_kind;
        logic        [1:0]  motor_slot;
        logic        [15:0] rotor_angle;
        logic signed [15:0] speed_or_torque;
        logic signed [15:0] measured_current;
        logic        [7:0]  temperature;
        logic signed [15:0] mean_current;
        logic signed [15:0] signed_angle;
    } cmfd_result_t;

    // beat carried along the cell chain
    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          slot;
        logic [15:0]         angle;
        logic [15:0]         rate;
        logic [SAMPLE_W-1:0] cur;
        logic [7:0]          temp;
        logic [SUM_W-1:0]    sum;
        logic [15:0]         sangle;
    } cmfd_beat_t;

endpackage

`default_nettype wire

/* hdl/cmfd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmfd_decode
    import cmfd_pkg::*;
#(
    parameter int CHASSIS_MOTORS = CMFD_CHASSIS_MOTORS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        frame_valid,
    output logic             frame_stall,
    input  wire cmfd_frame_t frame,
    output logic             dn_valid,
    output cmfd_beat_t       dn_beat,
    input  wire logic        dn_ready
);

    logic        v_reg;
    cmfd_beat_t  beat_reg;
    cmfd_beat_t  beat_next;
    logic [15:0] held_reg [2];
    logic [15:0] held_next;

    logic [15:0] angle;
    logic [10:0] ch_off;
    logic        is_ch;
    logic        is_gb;
    logic        is_fd;
    logic        g_idx;
    logic        ready;

    assign angle = frame.payload[63:48];
    assign ch_off = frame.frame_id - ID_CHASSIS_BASE;

    // identifier dispatch
    always_comb
    begin
        is_ch = (frame.frame_id >= ID_CHASSIS_BASE) && (ch_off < 11'(CHASSIS_MOTORS));
        is_gb = (frame.frame_id == ID_GIMBAL_0) || (frame.frame_id == ID_GIMBAL_1);
        is_fd = (frame.frame_id == ID_FEEDER);
        g_idx = (frame.frame_id == ID_GIMBAL_1);
    end

    // gimbal angle fold, exact midpoint keeps the held value
    always_comb
    begin
        if (angle < FOLD_MID)
            held_next = angle;
        else if (angle > FOLD_MID)
            held_next = angle - FOLD_SPAN;
        else
            held_next = held_reg[g_idx];
    end

    // beat fields by kind
    always_comb
    begin
        beat_next        = '0;
        beat_next.angle  = angle;
        beat_next.rate   = frame.payload[47:32];
        if (is_ch)
        begin
            beat_next.kind = KIND_CHASSIS;
            beat_next.slot = ch_off[1:0];
            beat_next.cur  = frame.payload[31:16];
            beat_next.temp = frame.payload[15:8];
        end
        else if (is_gb)
        begin
            beat_next.kind   = KIND_GIMBAL;
            beat_next.slot   = {1'b0, g_idx};
            beat_next.cur    = frame.payload[31:16];
            beat_next.sangle = held_next;
        end
        else
        begin
            beat_next.kind = KIND_FEEDER;
        end
    end

    assign ready       = !v_reg || dn_ready;
    assign frame_stall = !ready;

    // valid bit and held angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= 1'b0;
            held_reg[0] <= '0;
            held_reg[1] <= '0;
        end
        else if (ready)
        begin
            v_reg <= frame_valid && (is_ch || is_gb || is_fd);
            if (frame_valid && is_gb)
                held_reg[g_idx] <= held_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready && frame_valid)
            beat_reg <= beat_next;
    end

    assign dn_valid = v_reg;
    assign dn_beat  = beat_reg;

endmodule

`default_nettype wire

/* hdl/cmfd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmfd_cell
    import cmfd_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int WINDOW_LEN = CMFD_WINDOW_LEN
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       up_valid,
    input  wire cmfd_beat_t up_beat,
    output logic            up_ready,
    output logic            dn_valid,
    output cmfd_beat_t      dn_beat,
    input  wire logic       dn_ready
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    logic                v_reg;
    cmfd_beat_t          beat_reg;
    cmfd_beat_t          beat_next;
    logic [SAMPLE_W-1:0] tap_reg [WINDOW_LEN];
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                full;
    logic                hit;
    logic                ld;
    logic [SUM_W-1:0]    cur_ext;
    logic [SUM_W-1:0]    old_ext;

    assign up_ready = !v_reg || dn_ready;
    assign ld       = up_valid && up_ready;
    assign hit      = (up_beat.kind == KIND_CHASSIS) && (up_beat.slot == 2'(IDX));
    assign full     = (cnt_reg == CNT_W'(WINDOW_LEN));

    // running sum: add newest, drop oldest once the window is full
    always_comb
    begin
        cur_ext  = {{(SUM_W - SAMPLE_W){up_beat.cur[SAMPLE_W-1]}}, up_beat.cur};
        old_ext  = {{(SUM_W - SAMPLE_W){tap_reg[WINDOW_LEN-1][SAMPLE_W-1]}},
                    tap_reg[WINDOW_LEN-1]};
        sum_next = sum_reg + cur_ext - (full ? old_ext : '0);
    end

    always_comb
    begin
        beat_next = up_beat;
        if (hit)
            beat_next.sum = sum_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (up_ready)
                v_reg <= up_valid;
            if (ld && hit)
            begin
                sum_reg <= sum_next;
                if (!full)
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // sample shift line and beat payload
    always_ff @(posedge clk)
    begin
        if (ld)
            beat_reg <= beat_next;
        if (ld && hit)
        begin
            tap_reg[0] <= up_beat.cur;
            for (int i = 1; i < WINDOW_LEN; i++)
                tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dn_valid = v_reg;
    assign dn_beat  = beat_reg;

endmodule

`default_nettype wire

/* hdl/cmfd_avg.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmfd_avg
    import cmfd_pkg::*;
#(
    parameter int WINDOW_LEN = CMFD_WINDOW_LEN
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       up_valid,
    input  wire cmfd_beat_t up_beat,
    output logic            up_ready,
    output logic            result_valid,
    output cmfd_result_t    result,
    input  wire logic       result_stall
);

    // reciprocal scale: exact floor for sums of up to 20 bits, window up to 16
    localparam int RECIP_SH = SUM_W + 5;
    localparam int RECIP    = ((1 << RECIP_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W   = SUM_W + RECIP_SH;

    logic             a_v_reg;
    logic             b_v_reg;
    logic             c_v_reg;
    cmfd_beat_t       a_beat_reg;
    cmfd_beat_t       b_beat_reg;
    logic [SUM_W-1:0] a_abs_reg;
    logic             a_neg_reg;
    logic             b_neg_reg;
    logic [PROD_W-1:0] b_prod_reg;
    cmfd_result_t     c_res_reg;
    cmfd_result_t     c_res_next;
    logic [SUM_W-1:0] abs_next;
    logic [SUM_W-1:0] quot;
    logic [SUM_W-1:0] quot_s;
    logic             a_rdy;
    logic             b_rdy;
    logic             c_rdy;

    assign c_rdy    = !c_v_reg || !result_stall;
    assign b_rdy    = !b_v_reg || c_rdy;
    assign a_rdy    = !a_v_reg || b_rdy;
    assign up_ready = a_rdy;

    // magnitude of the sum
    assign abs_next = up_beat.sum[SUM_W-1] ? (~up_beat.sum + SUM_W'(1)) : up_beat.sum;

    // quotient and sign restore, result assembly
    always_comb
    begin
        quot   = b_prod_reg[RECIP_SH +: SUM_W];
        quot_s = b_neg_reg ? (~quot + SUM_W'(1)) : quot;
        c_res_next.source_kind      = b_beat_reg.kind;
        c_res_next.motor_slot       = b_beat_reg.slot;
        c_res_next.rotor_angle      = b_beat_reg.angle;
        c_res_next.speed_or_torque  = b_beat_reg.rate;
        c_res_next.measured_current = b_beat_reg.cur;
        c_res_next.temperature      = b_beat_reg.temp;
        c_res_next.mean_current     = quot_s[15:0];
        c_res_next.signed_angle     = b_beat_reg.sangle;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
                a_v_reg <= up_valid;
            if (b_rdy)
                b_v_reg <= a_v_reg;
            if (c_rdy)
                c_v_reg <= b_v_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (a_rdy && up_valid)
        begin
            a_beat_reg <= up_beat;
            a_abs_reg  <= abs_next;
            a_neg_reg  <= up_beat.sum[SUM_W-1];
        end
        if (b_rdy && a_v_reg)
        begin
            b_beat_reg <= a_beat_reg;
            b_neg_reg  <= a_neg_reg;
            b_prod_reg <= PROD_W'(a_abs_reg) * PROD_W'(RECIP);
        end
        if (c_rdy && b_v_reg)
            c_res_reg <= c_res_next;
    end

    assign result_valid = c_v_reg;
    assign result       = c_res_reg;

endmodule

`default_nettype wire

/* hdl/can_motor_feedback_decoder.sv */
// a frame beat is registered in the decoder, in each chassis cell and in the averager's a, b and c stages
// throughput: one frame per cycle while not stalled; the matching chassis cell updates its window as the beat passes
// frames with unlisted identifiers are taken and give no result beat
// reset: asynchronous, clears stage valids, fill counts, running sums and held gimbal angles
// sample shift lines are not reset; a sample is read only once its window is full
`timescale 1ns / 1ps
`default_nettype none

module can_motor_feedback_decoder
    import cmfd_pkg::*;
#(
    parameter int WINDOW_LEN     = CMFD_WINDOW_LEN,
    parameter int CHASSIS_MOTORS = CMFD_CHASSIS_MOTORS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        frame_valid,
    output logic             frame_stall,
    input  wire cmfd_frame_t frame,
    output logic             result_valid,
    input  wire logic        result_stall,
    output cmfd_result_t     result
);

    logic       ch_valid [CHASSIS_MOTORS + 1];
    logic       ch_ready [CHASSIS_MOTORS + 1];
    cmfd_beat_t ch_beat  [CHASSIS_MOTORS + 1];

    // frame decode and gimbal angle hold
    cmfd_decode #(
        .CHASSIS_MOTORS (CHASSIS_MOTORS)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .dn_valid    (ch_valid[0]),
        .dn_beat     (ch_beat[0]),
        .dn_ready    (ch_ready[0])
    );

    // one window cell per chassis motor
    for (genvar g = 0; g < CHASSIS_MOTORS; g++)
    begin : g_cell
        cmfd_cell #(
            .IDX        (g),
            .WINDOW_LEN (WINDOW_LEN)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ch_valid[g]),
            .up_beat  (ch_beat[g]),
            .up_ready (ch_ready[g]),
            .dn_valid (ch_valid[g+1]),
            .dn_beat  (ch_beat[g+1]),
            .dn_ready (ch_ready[g+1])
        );
    end

    // shared divide by window length and output register
    cmfd_avg #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_avg (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (ch_valid[CHASSIS_MOTORS]),
        .up_beat      (ch_beat[CHASSIS_MOTORS]),
        .up_ready     (ch_ready[CHASSIS_MOTORS]),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

/* tb/cmfd_checker.sv */
`timescale 1ns / 1ps

module cmfd_checker
    import cmfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         frame_valid,
    input  logic         frame_stall,
    input  cmfd_frame_t  frame,
    input  logic         result_valid,
    input  logic         result_stall,
    input  cmfd_result_t result,
    output int           mismatches,
    output int           pending
);

    // per-motor current windows and gimbal angle holders
    logic signed [15:0] current_window [CMFD_CHASSIS_MOTORS][CMFD_WINDOW_LEN];
    int                 window_sum     [CMFD_CHASSIS_MOTORS];
    int                 write_pos      [CMFD_CHASSIS_MOTORS];
    bit                 window_full    [CMFD_CHASSIS_MOTORS];
    logic        [15:0] gimbal_hold    [2];

    cmfd_result_t expected_results [$];

    // decode one frame and update the window state
    task automatic decode_frame(input cmfd_frame_t f);
        cmfd_result_t      r;
        logic [15:0]       angle;
        logic [15:0]       word23;
        logic [15:0]       word45;
        logic [10:0]       offset;
        int                slot;
        int                avg;
        bit                produced;
        angle    = f.payload[63:48];
        word23   = f.payload[47:32];
        word45   = f.payload[31:16];
        r        = '0;
        produced = 1'b0;
        r.rotor_angle     = angle;
        r.speed_or_torque = word23;
        offset = f.frame_id - ID_CHASSIS_BASE;
        if (f.frame_id >= ID_CHASSIS_BASE && offset < CMFD_CHASSIS_MOTORS)
        begin
            slot = int'(offset);
            if (write_pos[slot] >= CMFD_WINDOW_LEN)
                write_pos[slot] = 0;
            window_sum[slot] += $signed(word45);
            if (window_full[slot])
                window_sum[slot] -= current_window[slot][write_pos[slot]];
            current_window[slot][write_pos[slot]] = word45;
            write_pos[slot]++;
            if (write_pos[slot] >= CMFD_WINDOW_LEN)
            begin
                write_pos[slot]   = 0;
                window_full[slot] = 1'b1;
            end
            // int division truncates toward zero
            avg = window_sum[slot] / CMFD_WINDOW_LEN;
            r.source_kind      = KIND_CHASSIS;
            r.motor_slot       = slot[1:0];
            r.measured_current = word45;
            r.temperature      = f.payload[15:8];
            r.mean_current     = avg[15:0];
            produced = 1'b1;
        end
        else if (f.frame_id == ID_GIMBAL_0 || f.frame_id == ID_GIMBAL_1)
        begin
            slot = (f.frame_id == ID_GIMBAL_1) ? 1 : 0;
            // fold about the midpoint, hold the last value exactly at it
            if (angle < FOLD_MID)
                gimbal_hold[slot] = angle;
            else if (angle > FOLD_MID)
                gimbal_hold[slot] = angle - FOLD_SPAN;
            r.source_kind      = KIND_GIMBAL;
            r.motor_slot       = slot[1:0];
            r.measured_current = word45;
            r.signed_angle     = gimbal_hold[slot];
            produced = 1'b1;
        end
        else if (f.frame_id == ID_FEEDER)
        begin
            r.source_kind = KIND_FEEDER;
            produced = 1'b1;
        end
        if (produced)
            expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // compare result beats and predict from frame beats
    always @(posedge clk or negedge rst_n)
    begin
        cmfd_result_t want;
        if (!rst_n)
        begin
            for (int m = 0; m < CMFD_CHASSIS_MOTORS; m++)
            begin
                for (int k = 0; k < CMFD_WINDOW_LEN; k++)
                    current_window[m][k] = '0;
                window_sum[m]  = 0;
                write_pos[m]   = 0;
                window_full[m] = 1'b0;
            end
            gimbal_hold[0] = '0;
            gimbal_hold[1] = '0;
            expected_results.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none got %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("source_kind", 16'(want.source_kind),
                                16'(result.source_kind));
                    check_field("motor_slot", 16'(want.motor_slot),
                                16'(result.motor_slot));
                    check_field("rotor_angle", want.rotor_angle, result.rotor_angle);
                    check_field("speed_or_torque", want.speed_or_torque,
                                result.speed_or_torque);
                    check_field("measured_current", want.measured_current,
                                result.measured_current);
                    check_field("temperature", 16'(want.temperature),
                                16'(result.temperature));
                    check_field("mean_current", want.mean_current,
                                result.mean_current);
                    check_field("signed_angle", want.signed_angle, result.signed_angle);
                end
            end
            if (frame_valid && !frame_stall)
                decode_frame(frame);
            pending = expected_results.size();
        end
    end

endmodule

/* tb/tb_can_motor_feedback_decoder.sv */
`timescale 1ns / 1ps

module tb_can_motor_feedback_decoder;
    import cmfd_pkg::*;

    localparam int PHASE_ITEMS = 350;
    localparam int QUIET_LIMIT = 4000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         frame_valid = 1'b0;
    logic         frame_stall;
    cmfd_frame_t  frame = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    cmfd_result_t result;

    int mismatches;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    can_motor_feedback_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    cmfd_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // random back-pressure on the result side
    always @(posedge clk)
    begin
        if (rst_n)
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("can_motor_feedback_decoder verification failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pack_payload(input logic [15:0] angle,
                                                 input logic [15:0] rate,
                                                 input logic [15:0] current,
                                                 input logic [7:0]  temp,
                                                 input logic [7:0]  spare);
        return {angle, rate, current, temp, spare};
    endfunction

    // offer one frame beat, with random idle cycles ahead of it
    task automatic send_frame(input logic [10:0] id, input logic [63:0] data);
        bit took;
        while ($urandom_range(99) < idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= {id, data};
        do
        begin
            @(negedge clk);
            took = !frame_stall;
            @(posedge clk);
        end
        while (!took);
    endtask

    // random frames biased toward motors, with extreme-current bursts
    task automatic random_phase(input int items);
        logic [10:0] id;
        logic [63:0] data;
        logic [15:0] pick;
        logic [15:0] burst_cur;
        logic [10:0] burst_id;
        int          burst_left;
        int          sel;
        burst_left = 0;
        burst_cur  = '0;
        burst_id   = ID_CHASSIS_BASE;
        for (int n = 0; n < items; n++)
        begin
            data = {$urandom, $urandom};
            sel  = $urandom_range(99);
            if (burst_left == 0 && $urandom_range(99) < 3)
            begin
                burst_left = 12;
                burst_id   = ID_CHASSIS_BASE
                             + 11'($urandom_range(CMFD_CHASSIS_MOTORS - 1));
                burst_cur  = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            end
            if (burst_left > 0)
            begin
                id = burst_id;
                data[31:16] = burst_cur;
                burst_left--;
            end
            else if (sel < 55)
            begin
                id = ID_CHASSIS_BASE + 11'($urandom_range(CMFD_CHASSIS_MOTORS - 1));
                if ($urandom_range(3) == 0)
                begin
                    case ($urandom_range(3))
                        0: pick = 16'h8000;
                        1: pick = 16'h7fff;
                        2: pick = 16'hffff;
                        default: pick = 16'h0000;
                    endcase
                    data[31:16] = pick;
                end
            end
            else if (sel < 75)
            begin
                id = $urandom_range(1) ? ID_GIMBAL_1 : ID_GIMBAL_0;
                case ($urandom_range(4))
                    0: pick = FOLD_MID + 16'($urandom_range(2)) - 16'd1;
                    1: pick = 16'($urandom_range(8191));
                    2: pick = 16'd40960 - 16'($urandom_range(1));
                    default: pick = data[63:48];
                endcase
                data[63:48] = pick;
            end
            else if (sel < 85)
                id = ID_FEEDER;
            else
                id = 11'($urandom_range(2047));
            send_frame(id, data);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes on each chassis motor
        send_frame(ID_CHASSIS_BASE, pack_payload(16'hffff, 16'h7fff, 16'h7fff, 8'hff, 8'ha5));
        send_frame(ID_CHASSIS_BASE, pack_payload(16'h0000, 16'h8000, 16'h8000, 8'h00, 8'h5a));
        send_frame(ID_CHASSIS_BASE + 11'd1,
                   pack_payload(16'h1234, 16'hffff, 16'hffff, 8'h80, 8'hff));
        send_frame(ID_CHASSIS_BASE + 11'd2,
                   pack_payload(16'h8000, 16'h0001, 16'h0009, 8'h01, 8'h00));
        send_frame(ID_CHASSIS_BASE + 11'd3,
                   pack_payload(16'h7fff, 16'h0000, 16'hfff7, 8'h7f, 8'h00));
        send_frame(ID_CHASSIS_BASE + 11'd3,
                   pack_payload(16'hffff, 16'h8000, 16'h8000, 8'hff, 8'hff));

        // directed: gimbal fold points, including exactly the midpoint before any write
        send_frame(ID_GIMBAL_0, pack_payload(16'd4096, 16'h7fff, 16'h8000, 8'hff, 8'hff));
        send_frame(ID_GIMBAL_0, pack_payload(16'd4095, 16'h8000, 16'h7fff, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_0, pack_payload(16'd4096, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_0, pack_payload(16'd4097, 16'h0001, 16'hffff, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_0, pack_payload(16'd40959, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_0, pack_payload(16'd40960, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_0, pack_payload(16'hffff, 16'hffff, 16'h0000, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_0, pack_payload(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_1, pack_payload(16'd8192, 16'h1234, 16'h4321, 8'h00, 8'h00));
        send_frame(ID_GIMBAL_1, pack_payload(16'd4096, 16'h0000, 16'h0000, 8'hff, 8'hff));

        // directed: feeder
        send_frame(ID_FEEDER, {64{1'b1}});
        send_frame(ID_FEEDER, 64'h0);

        // directed: unlisted identifiers give nothing; base plus the motor count is gimbal 0 and gives a beat
        send_frame(11'h200, {64{1'b1}});
        send_frame(ID_CHASSIS_BASE + 11'(CMFD_CHASSIS_MOTORS), {64{1'b1}});
        send_frame(11'h208, {64{1'b1}});
        send_frame(11'h000, 64'h0);
        send_frame(11'h7ff, {64{1'b1}});

        // random phases with different idle and stall mixes
        idle_pct = 0;  stall_pct = 0;  random_phase(PHASE_ITEMS);
        idle_pct = 64; stall_pct = 0;  random_phase(PHASE_ITEMS);
        idle_pct = 0;  stall_pct = 64; random_phase(PHASE_ITEMS);
        idle_pct = 19; stall_pct = 19; random_phase(PHASE_ITEMS);
        frame_valid <= 1'b0;

        // drain, then give the pipeline time to show any extra beat
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4 * (CMFD_CHASSIS_MOTORS + 4)) @(negedge clk);

        if (mismatches == 0)
            $display("can_motor_feedback_decoder verification clean");
        else
            $display("can_motor_feedback_decoder verification failed");
        $finish;
    end

endmodule
